>>> rtl/cwt_pkg.sv
// Shared types, character codes and scan helpers for the C word tokenizer.
// No dependencies; the files that use it refer to this package by scoped names.
package cwt_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] LIMIT_RESET = 8'd99;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_EOI    = 2'd2;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_WORD   = 3'd1,
        M_STRING = 3'd2,
        M_LINE   = 3'd3,
        M_BLOCK  = 3'd4,
        M_BSTAR  = 3'd5,
        M_SLASH  = 3'd6
    } t_mode;

    typedef struct packed {
        logic [7:0] token_char;
        logic [1:0] token_kind;
        logic       last;
    } t_tok;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] held_char;
        logic       held_valid;
        logic [7:0] word_len;
    } t_scan;

    typedef struct packed {
        t_scan st;
        logic  emit;
        t_tok  tok;
    } t_fresh;

    // Step results handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        t_tok       res0;
        t_tok       res1;
    } t_push;

    localparam t_scan SCAN_RESET = '{mode: M_NORMAL, held_char: 8'd0,
                                     held_valid: 1'b0, word_len: 8'd0};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return is_alpha(c) || c == CH_HASH || c == CH_UNDER;
    endfunction

    function automatic logic word_more(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
    endfunction

    // Scan one character from normal mode
    function automatic t_fresh scan_fresh(input logic [7:0] c, input logic [7:0] eff,
                                          input t_scan st);
        t_fresh f;
        f.st      = st;
        f.st.mode = M_NORMAL;
        f.emit    = 1'b0;
        f.tok     = '0;
        if (is_space(c)) begin
            f.emit = 1'b0;
        end else if (c == CH_QUOTE) begin
            f.st.mode = M_STRING;
        end else if (c == CH_SLASH) begin
            f.st.mode = M_SLASH;
        end else if (word_start(c)) begin
            if (eff <= 8'd1) begin
                f.st   = SCAN_RESET;
                f.emit = 1'b1;
                f.tok  = '{token_char: c, token_kind: KIND_WORD, last: 1'b1};
            end else begin
                f.st.mode       = M_WORD;
                f.st.held_char  = c;
                f.st.held_valid = 1'b1;
                f.st.word_len   = 8'd1;
            end
        end else begin
            f.emit = 1'b1;
            f.tok  = '{token_char: c, token_kind: KIND_SINGLE, last: 1'b1};
        end
        return f;
    endfunction

endpackage

>>> rtl/cwt_in_if.sv
// Input character channel: valid/ready handshake with one source byte per beat.
// Stand-alone; no package dependency.
interface cwt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

>>> rtl/cwt_out_if.sv
// Token output channel: valid/ready handshake with one token character per beat.
// Stand-alone; no package dependency.
interface cwt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_char;
    logic [1:0] token_kind;
    logic       last;

    modport source (output valid, output token_char, output token_kind, output last,
                    input ready);
    modport sink   (input valid, input token_char, input token_kind, input last,
                    output ready);
endinterface

>>> rtl/cwt_step.sv
// Scan step: next scan state and up to two token beats for one character.
// Depends on cwt_pkg.
module cwt_step (
    input  cwt_pkg::t_scan i_scan,
    input  logic [7:0]     i_limit,
    input  logic [7:0]     i_char,
    input  logic           i_eoi,
    output cwt_pkg::t_scan o_scan,
    output cwt_pkg::t_push o_push
);

    logic [7:0]      eff;
    logic [7:0]      len_inc;
    cwt_pkg::t_fresh fr;
    cwt_pkg::t_tok   slash_tok;

    assign eff       = (i_limit == 8'd0) ? 8'd1 : i_limit;
    assign len_inc   = i_scan.word_len + 8'd1;
    assign slash_tok = '{token_char: cwt_pkg::CH_SLASH, token_kind: cwt_pkg::KIND_SINGLE,
                         last: 1'b1};

    always_comb begin
        o_scan = i_scan;
        o_push = '0;
        fr     = '0;
        if (i_eoi) begin
            // flush a pending word character or slash, then the marker
            if (i_scan.mode == cwt_pkg::M_WORD && i_scan.held_valid) begin
                o_push.res0  = '{token_char: i_scan.held_char,
                                 token_kind: cwt_pkg::KIND_WORD, last: 1'b1};
                o_push.count = 2'd1;
            end else if (i_scan.mode == cwt_pkg::M_SLASH) begin
                o_push.res0  = slash_tok;
                o_push.count = 2'd1;
            end
            if (o_push.count == 2'd0) begin
                o_push.res0 = '{token_char: 8'd0, token_kind: cwt_pkg::KIND_EOI,
                                last: 1'b1};
            end else begin
                o_push.res1 = '{token_char: 8'd0, token_kind: cwt_pkg::KIND_EOI,
                                last: 1'b1};
            end
            o_push.count = o_push.count + 2'd1;
            o_scan       = cwt_pkg::SCAN_RESET;
        end else begin
            case (i_scan.mode)
                cwt_pkg::M_WORD: begin
                    if (i_scan.held_valid && cwt_pkg::word_more(i_char)) begin
                        o_push.res0  = '{token_char: i_scan.held_char,
                                         token_kind: cwt_pkg::KIND_WORD, last: 1'b0};
                        o_push.count = 2'd1;
                        if (len_inc >= eff) begin
                            // cut the word here
                            o_push.res1  = '{token_char: i_char,
                                             token_kind: cwt_pkg::KIND_WORD, last: 1'b1};
                            o_push.count = 2'd2;
                            o_scan       = cwt_pkg::SCAN_RESET;
                        end else begin
                            o_scan.held_char = i_char;
                            o_scan.word_len  = len_inc;
                        end
                    end else begin
                        if (i_scan.held_valid) begin
                            o_push.res0  = '{token_char: i_scan.held_char,
                                             token_kind: cwt_pkg::KIND_WORD, last: 1'b1};
                            o_push.count = 2'd1;
                        end
                        fr     = cwt_pkg::scan_fresh(i_char, eff, cwt_pkg::SCAN_RESET);
                        o_scan = fr.st;
                        if (fr.emit) begin
                            if (o_push.count == 2'd0) begin
                                o_push.res0 = fr.tok;
                            end else begin
                                o_push.res1 = fr.tok;
                            end
                            o_push.count = o_push.count + 2'd1;
                        end
                    end
                end
                cwt_pkg::M_STRING: begin
                    if (i_char == cwt_pkg::CH_QUOTE || i_char == cwt_pkg::CH_NL) begin
                        o_scan.mode = cwt_pkg::M_NORMAL;
                    end
                end
                cwt_pkg::M_LINE: begin
                    if (i_char == cwt_pkg::CH_NL) begin
                        o_scan.mode = cwt_pkg::M_NORMAL;
                    end
                end
                cwt_pkg::M_BLOCK: begin
                    if (i_char == cwt_pkg::CH_STAR) begin
                        o_scan.mode = cwt_pkg::M_BSTAR;
                    end
                end
                cwt_pkg::M_BSTAR: begin
                    if (i_char == cwt_pkg::CH_SLASH) begin
                        o_scan.mode = cwt_pkg::M_NORMAL;
                    end else if (i_char != cwt_pkg::CH_STAR) begin
                        o_scan.mode = cwt_pkg::M_BLOCK;
                    end
                end
                cwt_pkg::M_SLASH: begin
                    if (i_char == cwt_pkg::CH_SLASH) begin
                        o_scan.mode = cwt_pkg::M_LINE;
                    end else if (i_char == cwt_pkg::CH_STAR) begin
                        o_scan.mode = cwt_pkg::M_BLOCK;
                    end else begin
                        // lone slash: emit it, then scan this character afresh
                        o_push.res0  = slash_tok;
                        o_push.count = 2'd1;
                        fr           = cwt_pkg::scan_fresh(i_char, eff, i_scan);
                        o_scan       = fr.st;
                        if (fr.emit) begin
                            o_push.res1  = fr.tok;
                            o_push.count = 2'd2;
                        end
                    end
                end
                default: begin
                    fr     = cwt_pkg::scan_fresh(i_char, eff, cwt_pkg::SCAN_RESET);
                    o_scan = fr.st;
                    if (fr.emit) begin
                        o_push.res0  = fr.tok;
                        o_push.count = 2'd1;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/cwt_outq.sv
// Output queue: four-entry register FIFO taking up to two token beats per cycle.
// Depends on cwt_pkg and cwt_out_if.
module cwt_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cwt_pkg::t_push i_push,
    output logic           o_room,
    cwt_out_if.source      o_out
);

    cwt_pkg::t_tok                 r_mem [cwt_pkg::QUEUE_DEPTH];
    logic [cwt_pkg::QPTR_W-1:0]    r_wr;
    logic [cwt_pkg::QPTR_W-1:0]    r_rd;
    logic [cwt_pkg::QCNT_W-1:0]    r_count;
    logic [cwt_pkg::QCNT_W-1:0]    n_count;
    logic [cwt_pkg::QPTR_W-1:0]    wr_next;
    logic                          pop;
    cwt_pkg::t_tok                 head;

    assign pop     = o_out.valid && o_out.ready;
    assign wr_next = r_wr + cwt_pkg::QPTR_W'(1);
    assign o_room  = r_count <= cwt_pkg::QCNT_W'(cwt_pkg::QUEUE_DEPTH - 2);
    assign n_count = r_count + cwt_pkg::QCNT_W'(i_push.count)
                   - (pop ? cwt_pkg::QCNT_W'(1) : cwt_pkg::QCNT_W'(0));

    assign head             = r_mem[r_rd];
    assign o_out.valid      = r_count != '0;
    assign o_out.token_char = head.token_char;
    assign o_out.token_kind = head.token_kind;
    assign o_out.last       = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + cwt_pkg::QPTR_W'(i_push.count);
            r_rd    <= pop ? r_rd + cwt_pkg::QPTR_W'(1) : r_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cwt_pkg::QCNT_W'(cwt_pkg::QUEUE_DEPTH))
        else $error("output queue overfilled");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2) |-> o_room)
        else $error("double push without room");

    a_push_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd3)
        else $error("more than two beats pushed");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != cwt_pkg::QCNT_W'(cwt_pkg::QUEUE_DEPTH))
        |-> (r_wr - r_rd) == r_count[cwt_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/c_word_tokenizer.sv
// C word tokenizer: splits a byte stream of C-like text into token beats.
// Channels: i_in takes one source character (or an end-of-input flag) per beat;
// o_out gives one token character per beat with its kind and a last flag.
// A word character is held back one character so its last flag is known;
// strings, comments and whitespace give no beats.
// An accepted character is held in the input register and scanned from there;
// its beats are written into the output queue, which drives o_out.
// Throughput: one character per cycle while the queue holds two beats or fewer.
// The queue drains one beat per cycle while o_out is ready, so a run of characters
// that each yield two beats (word cut, lone slash followed by a token,
// end-of-input flush) fills it, and the scan register then holds until it drains.
// The user must write the word limit via i_cfg_wr_en/i_cfg_wr_data while idle
// (not enforced). Reset (synchronous, active low) sets the limit to 99, returns to
// normal scanning and empties the queue. When o_out stalls, the queue takes beats
// until it holds three or four, then the scan register holds and i_in.ready drops.
// Depends on cwt_pkg, cwt_in_if, cwt_out_if, cwt_step and cwt_outq.
module c_word_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    cwt_in_if.sink     i_in,
    cwt_out_if.source  o_out
);

    logic           r_in_vld;
    logic [7:0]     r_in_char;
    logic           r_in_eoi;
    logic [7:0]     r_word_limit;
    cwt_pkg::t_scan r_scan;
    cwt_pkg::t_scan n_scan;
    cwt_pkg::t_push step_push;
    cwt_pkg::t_push q_push;
    logic           room;
    logic           fire;

    assign fire       = r_in_vld && room;
    assign i_in.ready = !r_in_vld || fire;

    always_comb begin
        q_push = step_push;
        if (!fire) begin
            q_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_word_limit <= cwt_pkg::LIMIT_RESET;
            r_scan       <= cwt_pkg::SCAN_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (i_cfg_wr_en) begin
                r_word_limit <= i_cfg_wr_data;
            end
            if (fire) begin
                r_scan <= n_scan;
            end
        end
    end

    // capture a beat whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.char_in;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    cwt_step u_step (
        .i_scan  (r_scan),
        .i_limit (r_word_limit),
        .i_char  (r_in_char),
        .i_eoi   (r_in_eoi),
        .o_scan  (n_scan),
        .o_push  (step_push)
    );

    cwt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_room  (room),
        .o_out   (o_out)
    );

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan.mode == cwt_pkg::M_WORD) |-> r_scan.held_valid)
        else $error("word mode without a held character");

    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_eoi) |=> (r_scan == cwt_pkg::SCAN_RESET))
        else $error("end of input left scan state behind");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !room) |=> (r_in_vld && $stable(r_in_char) && $stable(r_scan)))
        else $error("scan register moved while queue full");

endmodule
